[rtl/upd_pkg.sv]
// Shared types, character constants and hex helpers for the URL percent decoder.
package upd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER_BIAS = 8'h41 - 8'd10;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // Number of decoded bytes one input character can produce at most.
    localparam int unsigned MAX_OUT = 3;

    // Escape tracking state.
    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_DIG  = 3'b100
    } t_esc_phase;

    // Work handed from the front end to the back end for one input character.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              count;
        logic                    fin;
    } t_plan;

    // Status of the plan queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_plan_stat;

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble value of a hex digit character.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= 8'h61) ? (c - CASE_FOLD) : c;
        if (u >= 8'h41) begin
            hex_value = 4'(u - CHAR_UPPER_BIAS);
        end else begin
            hex_value = 4'(u - CHAR_ZERO);
        end
    endfunction

endpackage

[rtl/upd_front.sv]
// Front end: accepts characters, tracks the escape state and builds a byte plan.
module upd_front
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char,
    input  logic       i_final,
    input  logic       i_full,
    output logic       o_plan_push,
    output t_plan      o_plan
);

    t_esc_phase r_phase, n_phase;
    logic [7:0] r_held, n_held;

    logic                    accept;
    logic                    v_fresh;
    logic [1:0]              v_n;
    logic [MAX_OUT-1:0][7:0] v_b;

    assign accept = i_push && !i_full;

    // Decide the bytes this character releases and the next escape state.
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        v_fresh = 1'b0;
        v_n     = 2'd0;
        v_b     = '0;

        case (r_phase)
            ESC_PCT: begin
                if (is_hex(i_char)) begin
                    n_held  = i_char;
                    n_phase = ESC_DIG;
                end else begin
                    v_b[v_n] = CHAR_PCT;
                    v_n      = v_n + 2'd1;
                    v_fresh  = 1'b1;
                end
            end
            ESC_DIG: begin
                if (is_hex(i_char)) begin
                    v_b[v_n] = {hex_value(r_held), hex_value(i_char)};
                    v_n      = v_n + 2'd1;
                    n_phase  = ESC_IDLE;
                end else begin
                    v_b[v_n] = CHAR_PCT;
                    v_n      = v_n + 2'd1;
                    v_b[v_n] = r_held;
                    v_n      = v_n + 2'd1;
                    v_fresh  = 1'b1;
                end
            end
            default: begin
                v_fresh = 1'b1;
            end
        endcase

        // A character with no escape pending.
        if (v_fresh) begin
            n_phase = ESC_IDLE;
            if (i_char == CHAR_PCT) begin
                n_phase = ESC_PCT;
            end else if (i_char == CHAR_PLUS) begin
                v_b[v_n] = CHAR_SPACE;
                v_n      = v_n + 2'd1;
            end else begin
                v_b[v_n] = i_char;
                v_n      = v_n + 2'd1;
            end
        end

        // End of string flushes whatever is held.
        if (i_final) begin
            if (n_phase == ESC_PCT) begin
                v_b[v_n] = CHAR_PCT;
                v_n      = v_n + 2'd1;
            end else if (n_phase == ESC_DIG) begin
                v_b[v_n] = CHAR_PCT;
                v_n      = v_n + 2'd1;
                v_b[v_n] = n_held;
                v_n      = v_n + 2'd1;
            end
            n_phase = ESC_IDLE;
        end
    end

    assign o_plan.bytes = v_b;
    assign o_plan.count = v_n;
    assign o_plan.fin   = i_final;
    assign o_plan_push  = accept && (v_n != 2'd0);

    // Escape state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    // Held digit needs no reset; it is only read while a digit is held.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    // A held digit is always a valid hex character.
    a_held_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ESC_DIG) |-> is_hex(r_held))
        else $error("held digit is not a hex character");

    // A final character always yields at least one byte.
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final) |-> o_plan_push)
        else $error("final character produced no bytes");

endmodule

[rtl/upd_plan_fifo.sv]
// Short queue of byte plans between the front end and the back end.
module upd_plan_fifo
    import upd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_plan      i_plan,
    input  logic       i_pop,
    output t_plan      o_head,
    output t_plan_stat o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_plan          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Occupancy never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("plan queue overfilled");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full plan queue");

endmodule

[rtl/upd_back.sv]
// Back end: releases plan bytes one per cycle into the output register when empty or popped.
module upd_back
    import upd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_plan      i_head,
    input  t_plan_stat i_stat,
    output logic       o_plan_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_char,
    output logic       o_final
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_final;

    logic       load_ok, take, last;
    logic [7:0] sel_byte;

    assign load_ok = !r_out_valid || i_pop;
    assign take    = load_ok && !i_stat.empty;
    assign last    = (r_idx == (i_head.count - 2'd1));
    assign o_plan_pop = take && last;

    // Pick the current byte of the head plan.
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.bytes[0];
            2'd1:    sel_byte = i_head.bytes[1];
            2'd2:    sel_byte = i_head.bytes[2];
            default: sel_byte = i_head.bytes[0];
        endcase
    end

    // Byte index within the head plan and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
            if (load_ok) begin
                r_out_valid <= !i_stat.empty;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_char  <= sel_byte;
            r_out_final <= i_head.fin && last;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_char  = r_out_char;
    assign o_final = r_out_final;

    // The byte index always lies inside the head plan.
    a_idx_in_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.empty |-> (r_idx < i_head.count))
        else $error("byte index beyond plan");

    // A plan is retired only together with its last byte.
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_plan_pop |=> (r_idx == 2'd0))
        else $error("index not rewound after plan retired");

endmodule

[rtl/url_percent_decoder_unit.sv]
// Top level of the streaming URL percent decoder.
//
//  Channel  | Handshake     | Payload            | Transaction when
//  ---------+---------------+--------------------+-------------------------
//  input    | i_push/o_full | i_char, i_final    | i_push && !o_full
//  result   | o_empty/i_pop | o_char, o_final    | i_pop && !o_empty
//
// One character is taken per cycle while the plan queue has room.
// Results leave one byte per cycle while i_pop is held; a character that
// releases two or three bytes occupies the back end until all are out, which
// the plan queue (PLAN_DEPTH entries) absorbs. The first result of a character
// passes the plan queue and the output register before it reaches the ports.
// Reset is synchronous and active low and clears the escape state and queues.
// o_full depends only on queue occupancy, not on i_pop.
module url_percent_decoder_unit
    import upd_pkg::*;
#(
    parameter int unsigned PLAN_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_char,
    input  logic       i_final,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_char,
    output logic       o_final
);

    t_plan      plan_in, plan_head;
    t_plan_stat plan_stat;
    logic       plan_push, plan_pop;

    // Front end: character classification and escape tracking.
    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_char      (i_char),
        .i_final     (i_final),
        .i_full      (plan_stat.full),
        .o_plan_push (plan_push),
        .o_plan      (plan_in)
    );

    // Plan queue between front and back.
    upd_plan_fifo #(
        .DEPTH (PLAN_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (plan_push),
        .i_plan  (plan_in),
        .i_pop   (plan_pop),
        .o_head  (plan_head),
        .o_stat  (plan_stat)
    );

    // Back end: byte serializer and output register.
    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (plan_head),
        .i_stat     (plan_stat),
        .o_plan_pop (plan_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_char     (o_char),
        .o_final    (o_final)
    );

    assign o_full = plan_stat.full;

endmodule
